FILE: src/floored_int64_alu_defines.svh
// Assertion macros for the ALU.
`ifndef FLOORED_INT64_ALU_DEFINES_SVH
`define FLOORED_INT64_ALU_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define FIA_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property that must hold on every clock edge, reset included.
`define FIA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: src/fia_pkg.sv
`default_nettype none
package fia_pkg;
    localparam int DataW = 64;
    localparam int PowLimitDefault = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        FLT_OK     = 2'd0,
        FLT_DIV0   = 2'd1,
        FLT_NEGEXP = 2'd2,
        FLT_BIGEXP = 2'd3
    } fault_t;

    // 64x64 multiply as 16 partial products of 16x16 bits
    localparam int MulDigW = 16;
    localparam int MulDigN = DataW / MulDigW;

    typedef struct packed {
        logic start;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DataW-1:0] prod;
    } mul_rsp_t;
endpackage
`default_nettype wire

FILE: src/floored_int64_alu.sv
`default_nettype none
// Signed 64-bit ALU with floored division and remainder and wrapping power.
// Input beat on s_axis: tdata = {rhs, lhs} (lhs in bits 63:0), tuser = func.
// Result beat on m_axis: tdata = value[63:0], fault[65:64], zero padded to 72.
// One beat is taken at a time; s_axis_tready is low from acceptance until the
// result has been moved into the output register, and rises with that move.
// Path from the accepting edge to m_axis_tvalid: add/sub, faults and unused
// codes go straight to the hand-off; multiply runs start, 16 partial products
// through one 16x16 multiplier, drain, hand-off; divide and remainder run setup,
// one restoring radix-2 step per cycle over 64 bits, sign fix-up, hand-off;
// power runs one multiply per unit of the exponent, all multiplies running
// through the same shared multiplier.
// The output register holds a result until m_axis_tready; a new beat is
// accepted while it waits, but its result stays in the unit until the output
// register frees. Reset (aresetn low, synchronous) drops any work in flight
// and clears m_axis_tvalid.
module floored_int64_alu #(
    parameter int POW_LIMIT = fia_pkg::PowLimitDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // lhs[63:0], rhs[127:64]
    input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // value[63:0], fault[65:64]
);
    import fia_pkg::*;

    localparam int ExpW = $clog2(POW_LIMIT + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_DFIX, ST_POW, ST_DONE
    } state_t;

    state_t state_reg;
    logic [2:0]       op_reg;
    logic [DataW-1:0] x_reg, y_reg, res_reg, rem_reg, quo_reg;
    logic [1:0]       flt_reg;
    logic [6:0]       step_reg;
    logic [ExpW-1:0]  exp_reg;
    logic             mwait_reg;
    logic [DataW-1:0] out_val_reg;
    logic [1:0]       out_flt_reg;
    logic             out_vld_reg;
    mul_req_t         mreq;
    mul_rsp_t         mrsp;

    logic [DataW-1:0] s_lhs, s_rhs, ux, uy;
    logic [DataW:0]   rtrial, rsh;
    logic             xn, yn;

    assign s_lhs = s_axis_tdata[63:0];
    assign s_rhs = s_axis_tdata[127:64];
    assign xn = x_reg[DataW-1];
    assign yn = y_reg[DataW-1];
    assign uy = yn ? -y_reg : y_reg;
    assign ux = xn ? -x_reg : x_reg;
    assign rsh = {rem_reg, quo_reg[DataW-1]};
    assign rtrial = rsh - {1'b0, uy};

    fia_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    always_comb begin
        mreq.start = 1'b0;
        mreq.a = x_reg;
        mreq.b = y_reg;
        if (state_reg == ST_POW) mreq.b = res_reg;
        if ((state_reg == ST_MUL || state_reg == ST_POW) && !mwait_reg
            && !(state_reg == ST_POW && exp_reg == '0))
            mreq.start = 1'b1;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_flt_reg, out_val_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            mwait_reg   <= 1'b0;
        end else begin
            if (m_axis_tready) out_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        op_reg    <= s_axis_tuser;
                        x_reg     <= s_lhs;
                        y_reg     <= s_rhs;
                        flt_reg   <= FLT_OK;
                        res_reg   <= '0;
                        mwait_reg <= 1'b0;
                        state_reg <= ST_DONE;
                        unique case (s_axis_tuser)
                            OP_ADD: res_reg <= s_lhs + s_rhs;
                            OP_SUB: res_reg <= s_lhs - s_rhs;
                            OP_MUL: state_reg <= ST_MUL;
                            OP_DIV, OP_MOD: begin
                                if (s_rhs == '0) flt_reg <= FLT_DIV0;
                                else state_reg <= ST_DIV;
                            end
                            OP_POW: begin
                                if (s_rhs[DataW-1]) flt_reg <= FLT_NEGEXP;
                                else if (s_rhs > DataW'(POW_LIMIT)) flt_reg <= FLT_BIGEXP;
                                else begin
                                    res_reg   <= DataW'(1);
                                    exp_reg   <= s_rhs[ExpW-1:0];
                                    state_reg <= ST_POW;
                                end
                            end
                            default: ;
                        endcase
                        step_reg <= '0;
                    end
                end
                ST_MUL: begin
                    if (!mwait_reg) mwait_reg <= 1'b1;
                    else if (mrsp.done) begin
                        res_reg   <= mrsp.prod;
                        state_reg <= ST_DONE;
                    end
                end
                ST_POW: begin
                    if (exp_reg == '0) state_reg <= ST_DONE;
                    else if (!mwait_reg) mwait_reg <= 1'b1;
                    else if (mrsp.done) begin
                        res_reg   <= mrsp.prod;
                        exp_reg   <= exp_reg - 1'b1;
                        mwait_reg <= 1'b0;
                    end
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        quo_reg <= ux;
                        rem_reg <= '0;
                        step_reg <= 7'd1;
                    end else begin
                        if (!rtrial[DataW]) begin
                            rem_reg <= rtrial[DataW-1:0];
                            quo_reg <= {quo_reg[DataW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rsh[DataW-1:0];
                            quo_reg <= {quo_reg[DataW-2:0], 1'b0};
                        end
                        if (step_reg == 7'd64) state_reg <= ST_DFIX;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DFIX: begin
                    if (op_reg == OP_DIV) begin
                        if (xn != yn)
                            res_reg <= -quo_reg - DataW'(rem_reg != '0);
                        else
                            res_reg <= quo_reg;
                    end else begin
                        res_reg <= (xn ? -rem_reg : rem_reg)
                                   + ((rem_reg != '0 && xn != yn) ? y_reg : '0);
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!out_vld_reg || m_axis_tready) begin
                        out_vld_reg <= 1'b1;
                        out_val_reg <= (flt_reg != FLT_OK) ? '0 : res_reg;
                        out_flt_reg <= flt_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "floored_int64_alu_defines.svh"
    `FIA_ASSERT_CLK(a_fault_zero, (m_axis_tvalid && m_axis_tdata[65:64] != FLT_OK) |-> (m_axis_tdata[63:0] == '0), "faulted result not zero")
    `FIA_ASSERT_CLK(a_ready_idle, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "accepted while busy")
    `FIA_ASSERT_ALWAYS(a_rst_clear, !$past(aresetn) |-> !m_axis_tvalid, "valid after reset")
endmodule
`default_nettype wire

FILE: src/fia_mul.sv
`default_nettype none
module fia_mul (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire fia_pkg::mul_req_t req,
    output fia_pkg::mul_rsp_t  rsp
);
    import fia_pkg::*;

    localparam int CntW = $clog2(MulDigN * MulDigN);

    logic [DataW-1:0] a_reg, b_reg, acc_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg, done_reg;
    logic [CntW/2-1:0] ia, ib;
    logic [MulDigW-1:0] da, db;
    logic [2*MulDigW-1:0] pp_reg;
    logic             pp_vld_reg, pp_last_reg;
    logic [CntW-1:0]  pp_sh_reg;
    logic [DataW-1:0] pp_ext;

    assign ia = cnt_reg[CntW/2-1:0];
    assign ib = cnt_reg[CntW-1:CntW/2];
    assign da = a_reg[ia*MulDigW +: MulDigW];
    assign db = b_reg[ib*MulDigW +: MulDigW];
    assign pp_ext = DataW'(pp_reg) << (MulDigW * (32'(pp_sh_reg[CntW/2-1:0])
                    + 32'(pp_sh_reg[CntW-1:CntW/2])));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg      <= req.a;
                b_reg      <= req.b;
                acc_reg    <= '0;
                cnt_reg    <= '0;
                busy_reg   <= 1'b1;
                pp_vld_reg <= 1'b0;
            end else begin
                pp_vld_reg <= busy_reg;
                if (busy_reg) begin
                    pp_reg      <= da * db;
                    pp_sh_reg   <= cnt_reg;
                    pp_last_reg <= &cnt_reg;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (&cnt_reg) busy_reg <= 1'b0;
                end
                if (pp_vld_reg) begin
                    acc_reg <= acc_reg + pp_ext;
                    if (pp_last_reg) done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg | pp_vld_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule
`default_nettype wire
